@@ rtl/signed_int_to_decimal_ascii_core_assert.svh @@
// assertion macros used by the rtl file signed_int_to_decimal_ascii_core.sv
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SITDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SITDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SITDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SITDA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/sitda_pkg.sv @@
package sitda_pkg;

    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_SKIP  = 5'b00010,
        E_SIGN  = 5'b00100,
        E_DIGIT = 5'b01000,
        E_NL    = 5'b10000
    } t_emit_state;

    typedef struct packed {
        logic start;
        logic negative;
    } t_emit_cmd;

endpackage

@@ rtl/sitda_value_if.sv @@
interface sitda_value_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

@@ rtl/sitda_text_if.sv @@
interface sitda_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last;

    modport source (output valid, output text_byte, output last, input ready);
    modport sink (input valid, input text_byte, input last, output ready);
endinterface

@@ rtl/sitda_dabble.sv @@
module sitda_dabble #(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VALUE_WIDTH-1:0]  i_mag,
    output logic                    o_done,
    output logic [4*NUM_DIGITS-1:0] o_bcd
);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0]  r_shift, n_shift;
    logic [4*NUM_DIGITS-1:0] r_bcd, n_bcd;
    logic [4*NUM_DIGITS-1:0] w_adj;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_run, n_run;
    logic                    r_done, n_done;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_run   = r_run;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_mag;
            n_bcd   = '0;
            n_cnt   = CW'(VALUE_WIDTH);
            n_run   = 1'b1;
        end else if (r_run) begin
            n_bcd   = {w_adj[4*NUM_DIGITS-2:0], r_shift[VALUE_WIDTH-1]};
            n_shift = {r_shift[VALUE_WIDTH-2:0], 1'b0};
            n_cnt   = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;
endmodule

@@ rtl/sitda_emit.sv @@
module sitda_emit #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sitda_pkg::t_emit_cmd    i_cmd,
    input  logic [4*NUM_DIGITS-1:0] i_bcd,
    sitda_text_if.source            o_text
);
    import sitda_pkg::*;

    localparam int LW = $clog2(NUM_DIGITS + 1);

    t_emit_state             r_state, n_state;
    logic [4*NUM_DIGITS-1:0] r_dig, n_dig;
    logic [LW-1:0]           r_left, n_left;
    logic                    r_neg, n_neg;
    logic                    r_valid, n_valid;
    logic [7:0]              r_byte, n_byte;
    logic                    r_last, n_last;
    logic                    w_can_load;
    logic [3:0]              w_top;

    assign w_can_load = !r_valid || o_text.ready;
    assign w_top      = r_dig[4*NUM_DIGITS-1 -: 4];

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_left  = r_left;
        n_neg   = r_neg;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        if (r_valid && o_text.ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            E_IDLE: begin
                if (i_cmd.start) begin
                    n_dig   = i_bcd;
                    n_left  = LW'(NUM_DIGITS);
                    n_neg   = i_cmd.negative;
                    n_state = E_SKIP;
                end
            end
            E_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (w_top == 4'd0 && r_left > LW'(1)) begin
                    n_dig  = {r_dig[4*NUM_DIGITS-5:0], 4'd0};
                    n_left = r_left - LW'(1);
                end else if (r_neg) begin
                    n_state = E_SIGN;
                end else begin
                    n_state = E_DIGIT;
                end
            end
            E_SIGN: begin
                if (w_can_load) begin
                    n_valid = 1'b1;
                    n_byte  = CH_MINUS;
                    n_last  = 1'b0;
                    n_state = E_DIGIT;
                end
            end
            E_DIGIT: begin
                if (w_can_load) begin
                    n_valid = 1'b1;
                    n_byte  = CH_ZERO | {4'd0, w_top};
                    n_last  = 1'b0;
                    n_dig   = {r_dig[4*NUM_DIGITS-5:0], 4'd0};
                    n_left  = r_left - LW'(1);
                    if (r_left == LW'(1)) begin
                        n_state = E_NL;
                    end
                end
            end
            E_NL: begin
                if (w_can_load) begin
                    n_valid = 1'b1;
                    n_byte  = CH_NEWLINE;
                    n_last  = 1'b1;
                    n_state = E_IDLE;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dig  <= n_dig;
        r_left <= n_left;
        r_neg  <= n_neg;
        r_byte <= n_byte;
        r_last <= n_last;
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_text.valid     = r_valid;
    assign o_text.text_byte = r_byte;
    assign o_text.last      = r_last;
endmodule

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// conversion: the double dabble shift takes one bit per cycle, then leading zeros
//   are dropped before the first byte; the output shifter then sends one digit per
//   cycle while the output is not stalled, after a minus byte for a negative value;
//   a new word is not taken until the newline byte of the last one is accepted
// reset: synchronous active-low i_rst_n clears control and the output valid
`include "signed_int_to_decimal_ascii_core_assert.svh"

module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sitda_value_if.sink  i_value,
    sitda_text_if.source o_text
);
    import sitda_pkg::*;

    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

    logic                    r_busy, n_busy;
    logic                    r_neg, n_neg;
    logic                    w_accept;
    logic [VALUE_WIDTH-1:0]  w_v;
    logic [VALUE_WIDTH-1:0]  w_mag;
    logic                    w_conv_done;
    logic [4*NUM_DIGITS-1:0] w_bcd;
    t_emit_cmd               w_cmd;

    assign i_value.ready = !r_busy;
    assign w_accept      = i_value.valid && !r_busy;
    assign w_v           = i_value.value;
    // most negative value wraps to the sign bit alone, its true magnitude
    assign w_mag         = w_v[VALUE_WIDTH-1] ? (~w_v + VALUE_WIDTH'(1)) : w_v;

    always_comb begin
        n_busy = r_busy;
        n_neg  = r_neg;
        if (w_accept) begin
            n_busy = 1'b1;
            n_neg  = w_v[VALUE_WIDTH-1];
        end else if (o_text.valid && o_text.ready && o_text.last) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    assign w_cmd.start    = w_conv_done;
    assign w_cmd.negative = r_neg;

    sitda_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_mag   (w_mag),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    sitda_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_bcd   (w_bcd),
        .o_text  (o_text)
    );

    `SITDA_ASSERT(a_out_only_busy, i_clk, i_rst_n, o_text.valid |-> r_busy, "word out while idle")
    `SITDA_ASSERT(a_conv_only_busy, i_clk, i_rst_n, w_conv_done |-> r_busy, "conversion done while idle")
    `SITDA_ASSERT(a_last_is_nl, i_clk, i_rst_n, (o_text.valid && o_text.last) |-> (o_text.text_byte == CH_NEWLINE), "last word not newline")
    `SITDA_ASSERT(a_accept_blocks, i_clk, i_rst_n, w_accept |=> !i_value.ready, "ready right after accept")
    `SITDA_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !r_busy, "busy after reset")
endmodule

@@ verif/signed_int_to_decimal_ascii_core_tb.sv @@
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_core_tb;

    import sitda_pkg::*;

    localparam int VW = 32;

    typedef struct {
        logic signed [VW-1:0] value;
        bit                   drain;
    } t_value_item;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    sitda_value_if #(.VALUE_WIDTH(VW)) value_bus ();
    sitda_text_if                      text_bus ();

    signed_int_to_decimal_ascii_core #(
        .VALUE_WIDTH(VW)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (value_bus),
        .o_text  (text_bus)
    );

    t_value_item value_q[$];
    t_text_char  text_expect_q[$];
    t_value_item cur_item;
    int          err_count = 0;
    bit          sending = 0;
    bit          word_taken = 0;
    int          gap_left = 0;
    int          send_calm = 0;
    int          stall_left = 0;
    int          ready_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_500_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void predict_decimal_text(input logic signed [VW-1:0] value);
        logic [VW:0] mag;
        logic [7:0]  digit_q[$];
        bit          negative;
        negative = value[VW-1];
        // one bit wider so the most negative value keeps its true magnitude
        mag = negative ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
        do begin
            digit_q.push_front(CH_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (negative) text_expect_q.push_back(t_text_char'{CH_MINUS, 1'b0});
        foreach (digit_q[i]) text_expect_q.push_back(t_text_char'{digit_q[i], 1'b0});
        text_expect_q.push_back(t_text_char'{CH_NEWLINE, 1'b1});
    endfunction

    function automatic logic signed [VW-1:0] rand_value();
        int              roll;
        int              ndig;
        bit              neg;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        roll = $urandom_range(0, 99);
        neg  = $urandom_range(0, 1);
        if (roll < 30) return $urandom;
        if (roll < 40) return $urandom_range(0, 40) - 20;
        if (roll < 50) begin
            if (neg) return {1'b1, {(VW-1){1'b0}}} + $urandom_range(0, 5);
            return {1'b0, {(VW-1){1'b1}}} - $urandom_range(0, 5);
        end
        ndig = $urandom_range(1, 10);
        lo = (ndig == 1) ? 0 : 64'd10 ** (ndig - 1);
        hi = 64'd10 ** ndig - 1;
        if (neg && hi > 64'd2147483648) hi = 64'd2147483648;
        if (!neg && hi > 64'd2147483647) hi = 64'd2147483647;
        mag = lo + (longint'($urandom) % (hi - lo + 1));
        return neg ? VW'(-mag) : VW'(mag);
    endfunction

    // word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            value_bus.valid <= 1'b0;
        end else begin
            if (word_taken) begin
                word_taken = 1'b0;
                sending    = 1'b0;
                if (send_calm > 0) begin
                    send_calm--;
                    gap_left = 0;
                end else begin
                    gap_left = pick_gap();
                    if ($urandom_range(0, 29) == 0) send_calm = 25;
                end
            end
            if (!sending) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (value_q.size() > 0 &&
                             (!value_q[0].drain || text_expect_q.size() == 0)) begin
                    cur_item = value_q.pop_front();
                    sending  = 1'b1;
                end
            end
            value_bus.valid <= sending;
            value_bus.value <= sending ? cur_item.value : $urandom;
        end
    end

    // text ready with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            text_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            text_bus.ready <= 1'b0;
        end else begin
            text_bus.ready <= 1'b1;
            if (ready_calm > 0) begin
                ready_calm--;
            end else if ($urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
            end else if ($urandom_range(0, 199) == 0) begin
                ready_calm = 150;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_text_char exp_char;
        if (i_rst_n) begin
            if (value_bus.valid && value_bus.ready) begin
                predict_decimal_text(value_bus.value);
                word_taken = 1'b1;
            end
            if (text_bus.valid && text_bus.ready) begin
                if (text_expect_q.size() == 0) begin
                    $display("%0t: unexpected word text_byte=%0d last=%0b", $time,
                             text_bus.text_byte, text_bus.last);
                    err_count++;
                end else begin
                    exp_char = text_expect_q.pop_front();
                    if (text_bus.text_byte !== exp_char.ch) begin
                        $display("%0t: text_byte mismatch expected=%0d actual=%0d", $time,
                                 exp_char.ch, text_bus.text_byte);
                        err_count++;
                    end
                    if (text_bus.last !== exp_char.last) begin
                        $display("%0t: last mismatch expected=%0b actual=%0b", $time,
                                 exp_char.last, text_bus.last);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        logic signed [VW-1:0] directed[$];
        i_rst_n         = 1'b0;
        value_bus.valid = 1'b0;
        value_bus.value = '0;
        text_bus.ready  = 1'b0;

        directed = '{0, 1, -1, 7, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                     999999999, 1000000000, -1000000000, 1234567890, -1234567890,
                     32'sh7fffffff, 32'sh7ffffffe, 32'sh80000001, 32'sh80000000,
                     32'sh55555555, 32'shaaaaaaaa};
        foreach (directed[i]) value_q.push_back(t_value_item'{directed[i], 1'b0});
        for (int i = 0; i < 370; i++) begin
            value_q.push_back(t_value_item'{rand_value(), (i == 0 || i == 120 || i == 250)});
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (value_q.size() != 0 || sending || text_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
